[rtl/imu_pkg.sv]
// imu_pkg: shared types and constants for the ising metropolis update block
// no dependencies; imported by the interfaces, controller and datapath
package imu_pkg;

  localparam int ROW_W = 6;
  localparam int ROW_SPAN = 2 ** ROW_W;
  localparam int FRAC_W = 16;
  localparam int DE_W = 5;
  localparam int MAG_W = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EIGHT = 1'b1;

  localparam logic [FRAC_W-1:0] THR_FOUR_RESET = 16'd4554;
  localparam logic [FRAC_W-1:0] THR_EIGHT_RESET = 16'd316;

  localparam logic signed [5:0] DE_FOUR = 6'sd4;
  localparam logic signed [5:0] DE_EIGHT = 6'sd8;
  localparam logic signed [5:0] DE_BASE = 6'sd8;

  localparam int MAG_MAX = 8191;
  localparam int MAG_MIN = -8192;

  typedef struct packed {
    logic clear;   // clearing pass, one row per cycle
    logic idle;    // read addresses come from the input request
    logic load;    // request accepted this cycle
    logic latch;   // first neighbor row arrives
    logic commit;  // decide, write back, load result
  } imu_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } imu_status_t;

endpackage

[rtl/imu_in_if.sv]
// imu_in_if: request channel of the ising metropolis update block
// depends on imu_pkg for field widths
interface imu_in_if
  import imu_pkg::*;
#(
  parameter int RANDOM_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       col;
  logic                   spin_down;
  logic [RANDOM_BITS-1:0] random_value;

  modport source (output valid, opcode, row, col, spin_down, random_value, input ready);
  modport sink (input valid, opcode, row, col, spin_down, random_value, output ready);
endinterface

[rtl/imu_out_if.sv]
// imu_out_if: result channel of the ising metropolis update block
// depends on imu_pkg for field widths
interface imu_out_if
  import imu_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    flipped;
  logic                    site_spin_down;
  logic signed [DE_W-1:0]  energy_change;
  logic signed [MAG_W-1:0] magnetization;

  modport source (output valid, flipped, site_spin_down, energy_change, magnetization,
                  input ready);
  modport sink (input valid, flipped, site_spin_down, energy_change, magnetization,
                output ready);
endinterface

[rtl/imu_ram.sv]
// imu_ram: generic ram, one write port and two registered read ports
// no dependencies
module imu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

[rtl/imu_ctrl.sv]
// imu_ctrl: sequencer for clearing, row fetch and commit
// depends on imu_pkg for the command and status structs
module imu_ctrl
  import imu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  imu_status_t status,
  output imu_cmd_t    cmd
);
  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_FETCH, ST_EXEC} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (status.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.idle   = (state_r == ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.latch  = (state_r == ST_FETCH);
  assign cmd.commit = (state_r == ST_EXEC) && status.out_free;
endmodule

[rtl/imu_datapath.sv]
// imu_datapath: row memory, site registers, metropolis decision, result register
// depends on imu_pkg and imu_ram
module imu_datapath
  import imu_pkg::*;
#(
  parameter int LATTICE_SIDE = 64,
  parameter int RANDOM_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  imu_cmd_t                cmd,
  output imu_status_t             status,
  input  logic                    in_opcode,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_col,
  input  logic                    in_spin_down,
  input  logic [RANDOM_BITS-1:0]  in_random_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_flipped,
  output logic                    out_site_spin_down,
  output logic signed [DE_W-1:0]  out_energy_change,
  output logic signed [MAG_W-1:0] out_magnetization
);
  localparam int IDX_W = $clog2(LATTICE_SIDE);
  localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
  localparam int TOT_W = $clog2(SITE_COUNT) + 2;
  localparam int CMP_W = (TOT_W > MAG_W) ? TOT_W : MAG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LATTICE_SIDE - 1);

  function automatic logic [ROW_SPAN*IDX_W-1:0] wrap_table();
    logic [ROW_SPAN*IDX_W-1:0] t;
    t = '0;
    for (int i = 0; i < ROW_SPAN; i++) begin
      t[i*IDX_W +: IDX_W] = IDX_W'(i % LATTICE_SIDE);
    end
    return t;
  endfunction

  localparam logic [ROW_SPAN*IDX_W-1:0] WRAP_TBL = wrap_table();

  // thresholds
  logic [FRAC_W-1:0] thr_four_r, thr_eight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_four_r  <= THR_FOUR_RESET;
      thr_eight_r <= THR_EIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR_FOUR:  thr_four_r  <= cfg_wdata;
        REG_THR_EIGHT: thr_eight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request fields, wrapped into the lattice
  logic [IDX_W-1:0]  row_in_w, col_in_w, up_in;
  logic [FRAC_W-1:0] rnd_in;

  assign row_in_w = WRAP_TBL[in_row*IDX_W +: IDX_W];
  assign col_in_w = WRAP_TBL[in_col*IDX_W +: IDX_W];
  assign up_in    = (row_in_w == '0) ? LAST_IDX : row_in_w - 1'b1;

  generate
    if (RANDOM_BITS >= FRAC_W) begin : g_rnd_hi
      assign rnd_in = in_random_value[RANDOM_BITS-1 -: FRAC_W];
    end else begin : g_rnd_lo
      assign rnd_in = {in_random_value, {(FRAC_W-RANDOM_BITS){1'b0}}};
    end
  endgenerate

  logic [IDX_W-1:0]  row_r, col_r;
  logic              op_r, spin_down_r;
  logic [FRAC_W-1:0] rnd_r;
  logic              up_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r       <= row_in_w;
      col_r       <= col_in_w;
      op_r        <= in_opcode;
      spin_down_r <= in_spin_down;
      rnd_r       <= rnd_in;
    end
  end

  // row memory, cleared row by row after reset
  logic [IDX_W-1:0]        clr_cnt_r;
  logic [IDX_W-1:0]        dn_idx, lf_idx, rt_idx;
  logic [IDX_W-1:0]        raddr0, raddr1, waddr;
  logic [LATTICE_SIDE-1:0] rdata0, rdata1, wdata, row_new;
  logic                    ram_we;

  assign dn_idx = (row_r == LAST_IDX) ? '0 : row_r + 1'b1;
  assign lf_idx = (col_r == '0) ? LAST_IDX : col_r - 1'b1;
  assign rt_idx = (col_r == LAST_IDX) ? '0 : col_r + 1'b1;

  // port 0 holds the site row, port 1 gives the row above then the row below
  assign raddr0 = cmd.idle ? row_in_w : row_r;
  assign raddr1 = cmd.idle ? up_in : dn_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      up_bit_r <= rdata1[col_r];
    end
  end

  // metropolis decision
  logic                    old_bit, new_bit, flip, upd_flip;
  logic [2:0]              down_cnt;
  logic signed [5:0]       de_up, de6;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic signed [CMP_W-1:0] total_ext;
  logic signed [MAG_W-1:0] mag_sat;

  assign old_bit  = rdata0[col_r];
  assign down_cnt = 3'(up_bit_r) + 3'(rdata1[col_r]) + 3'(rdata0[lf_idx])
                  + 3'(rdata0[rt_idx]);
  // flip energy of an up spin is 8 - 4 * (down neighbors)
  assign de_up    = DE_BASE - $signed({1'b0, down_cnt, 2'b00});
  assign de6      = old_bit ? -de_up : de_up;
  assign upd_flip = (de6 <= 6'sd0)
                 || ((de6 == DE_FOUR) && (rnd_r < thr_four_r))
                 || ((de6 == DE_EIGHT) && (rnd_r < thr_eight_r));
  assign flip     = (op_r == OP_UPDATE) ? upd_flip : (spin_down_r != old_bit);
  assign new_bit  = old_bit ^ flip;

  always_comb begin
    row_new = rdata0;
    row_new[col_r] = new_bit;
  end

  assign ram_we = cmd.clear || cmd.commit;
  assign waddr  = cmd.clear ? clr_cnt_r : row_r;
  assign wdata  = cmd.clear ? '0 : row_new;

  imu_ram #(
    .WIDTH (LATTICE_SIDE),
    .DEPTH (LATTICE_SIDE)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // running magnetization, exact
  always_comb begin
    total_nxt = total_r;
    if (flip) begin
      total_nxt = old_bit ? total_r + TOT_W'(2) : total_r - TOT_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOT_W'(SITE_COUNT);
    end else if (cmd.commit) begin
      total_r <= total_nxt;
    end
  end

  assign total_ext = CMP_W'($signed(total_nxt));

  always_comb begin
    if (total_ext > CMP_W'(MAG_MAX)) begin
      mag_sat = MAG_W'(MAG_MAX);
    end else if (total_ext < CMP_W'(MAG_MIN)) begin
      mag_sat = MAG_W'(MAG_MIN);
    end else begin
      mag_sat = MAG_W'(total_ext);
    end
  end

  // result register
  logic                    out_valid_r;
  logic                    res_flip_r, res_spin_r;
  logic signed [DE_W-1:0]  res_de_r;
  logic signed [MAG_W-1:0] res_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_flip_r <= flip;
      res_spin_r <= new_bit;
      res_de_r   <= (op_r == OP_UPDATE) ? de6[DE_W-1:0] : '0;
      res_mag_r  <= mag_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_flipped        = res_flip_r;
  assign out_site_spin_down = res_spin_r;
  assign out_energy_change  = res_de_r;
  assign out_magnetization  = res_mag_r;

  assign status.clear_last = (clr_cnt_r == LAST_IDX);
  assign status.out_free   = !out_valid_r || out_ready;

  // every flip moves the total by two, so its parity never changes
  a_total_parity: assert property (@(posedge clk) disable iff (!rst_n)
    total_r[0] == SITE_COUNT[0])
    else $error("magnetization parity broken");

  a_no_flip_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !flip |=> $stable(total_r))
    else $error("total changed without a flip");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_de_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_de_r[1:0] == 2'b00))
    else $error("energy change not a multiple of four");
endmodule

[rtl/ising_metropolis_update.sv]
// ising_metropolis_update: top level, joins the sequencer and the datapath
// depends on imu_pkg, imu_in_if, imu_out_if, imu_ctrl, imu_datapath
//
// Keeps a LATTICE_SIDE x LATTICE_SIDE periodic lattice of spins in a row-wide
// memory and a running magnetization. Each request (spin write or metropolis
// update) is handled in full before the next is taken: accept plus read of the
// site row and the row above, read of the row below, then decision and
// write-back. Three rows through a memory with two read ports split the reads.
// One result waits in an output register, so a request is finished once the
// result slot is free. After reset the lattice is cleared one row per cycle,
// with no request taken meanwhile; threshold writes are taken at any time.
module ising_metropolis_update
  import imu_pkg::*;
#(
  parameter int LATTICE_SIDE = 64,
  parameter int RANDOM_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  imu_in_if.sink                in_req,
  imu_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  imu_cmd_t    cmd;
  imu_status_t status;

  imu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  imu_datapath #(
    .LATTICE_SIDE (LATTICE_SIDE),
    .RANDOM_BITS  (RANDOM_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_opcode          (in_req.opcode),
    .in_row             (in_req.row),
    .in_col             (in_req.col),
    .in_spin_down       (in_req.spin_down),
    .in_random_value    (in_req.random_value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_res.valid),
    .out_ready          (out_res.ready),
    .out_flipped        (out_res.flipped),
    .out_site_spin_down (out_res.site_spin_down),
    .out_energy_change  (out_res.energy_change),
    .out_magnetization  (out_res.magnetization)
  );
endmodule
